// ----- rtl/lu_pkg.sv -----
// Package for the LU linear system solver: fixed-point types, sequencer states
// and the status struct passed between the datapath units. No dependencies.
package lu_pkg;
    typedef logic signed [31:0] fx_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_ELEM,
        ST_TGT,
        ST_TERM_B,
        ST_TERM_M,
        ST_TERM_P,
        ST_TERM_ACC,
        ST_FIN,
        ST_CHECK,
        ST_PIV,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT_RD,
        ST_OUT
    } lu_state_t;

    typedef enum logic [1:0] {
        PH_U,
        PH_L,
        PH_F,
        PH_B
    } lu_phase_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

    localparam int SIZE_CAP = 8;

    function automatic fx_t sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction
endpackage

// ----- rtl/lu_divider.sv -----
// Sequential restoring divider: (num << FRAC_BITS) / den, truncating, saturated.
// Uses lu_pkg; one quotient bit per cycle.
module lu_divider #(
    parameter int FRAC_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  lu_pkg::fx_t      num,
    input  lu_pkg::fx_t      den,
    output lu_pkg::div_ctl_t ctl,
    output lu_pkg::fx_t      quo
);
    import lu_pkg::*;

    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] dvd_reg;
    logic [NW-1:0] q_reg;
    logic [32:0]   rem_reg;
    logic [31:0]   dmag_reg;
    logic          neg_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [33:0]   trial;
    logic [32:0]   shifted;
    logic [31:0]   nmag;
    logic signed [NW+1:0] qs;

    assign nmag    = num[31] ? 32'(-num) : 32'(num);
    assign shifted = {rem_reg[31:0], dvd_reg[NW-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dmag_reg};
    assign qs      = neg_reg ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= {nmag, {FRAC_BITS{1'b0}}};
            dmag_reg <= den[31] ? 32'(-den) : den;
            neg_reg  <= num[31] ^ den[31];
            rem_reg  <= '0;
            q_reg    <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[NW-2:0], 1'b0};
            if (!trial[33])
            begin
                rem_reg <= trial[32:0];
                q_reg   <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                q_reg   <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign ctl = {start, busy_reg, done_reg};
    assign quo = sat32(66'(qs));
endmodule

// ----- rtl/lu_linear_system_solver.sv -----
// LU linear system solver: loads a matrix and vector item by item, factors in place
// (Doolittle), substitutes forward and back, then emits the solution items.
// A non-last item is accepted every cycle. After the last item the solver computes each
// matrix or vector entry from its multiply-accumulate terms, divides each L entry and each
// back-substitution item by its pivot (read from the matrix in back substitution), checks
// each pivot, and emits each result item; the input stalls until the last result.
// Reset clears the sequencer and the singular flag and sets size_reg to 8.
module lu_linear_system_solver #(
    parameter int MAX_SIZE  = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [2:0]  row,
    input  logic [2:0]  col,
    input  lu_pkg::fx_t value,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  index,
    output lu_pkg::fx_t solution,
    output logic        singular,
    output logic        end_of_run
);
    import lu_pkg::*;

    localparam int IW  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int AW  = 2 * IW;
    localparam int CAP = (MAX_SIZE < SIZE_CAP) ? MAX_SIZE : SIZE_CAP;

    fx_t lu_mem [MAX_SIZE*MAX_SIZE];
    fx_t vec_mem [MAX_SIZE];

    lu_state_t state_reg, state_next;
    lu_phase_t phase_reg, phase_next;
    logic [3:0]  size_reg;
    logic [3:0]  n_reg;
    logic [3:0]  i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic        sing_reg, sing_next;
    logic signed [65:0] acc_reg, acc_next;
    logic signed [63:0] prod_reg;
    fx_t         a_reg, a_next, ma_reg, ma_next, mb_reg, mb_next, pivot_reg, pivot_next;
    fx_t         rd_lu, rd_vec;
    logic [AW-1:0] lu_addr;
    logic        lu_we;
    fx_t         lu_wd;
    logic [IW-1:0] vec_addr;
    logic        vec_we;
    fx_t         vec_wd;
    logic        div_start;
    div_ctl_t    div_ctl;
    fx_t         div_quo;
    fx_t         diff;
    logic [3:0]  n_eff;
    logic        in_acc;
    logic        in_ok;
    logic        is_vec;
    logic [3:0]  k_start, k_end;
    logic [AW-1:0] tgt_addr, a_addr, b_addr;

    lu_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (diff),
        .den   (pivot_reg),
        .ctl   (div_ctl),
        .quo   (div_quo)
    );

    function automatic logic [AW-1:0] adr(input logic [3:0] r, input logic [3:0] c);
        return AW'(r) * AW'(MAX_SIZE) + AW'(c);
    endfunction

    assign n_eff  = (size_reg == 4'd0) ? 4'd1 :
                    (size_reg > 4'(CAP)) ? 4'(CAP) : size_reg;
    assign in_acc = in_valid && !in_stall;
    assign in_ok  = (32'(row) < MAX_SIZE) && (mode || (32'(col) < MAX_SIZE));
    assign diff   = sat32(66'(a_reg) - acc_reg);
    assign in_stall = (state_reg != ST_LOAD);

    assign is_vec   = phase_reg inside {PH_F, PH_B};
    assign k_start  = (phase_reg == PH_B) ? i_reg + 4'd1 : 4'd0;
    assign k_end    = (phase_reg == PH_B) ? n_reg : i_reg;
    assign tgt_addr = (phase_reg == PH_L) ? adr(j_reg, i_reg) : adr(i_reg, j_reg);
    assign a_addr   = (phase_reg == PH_L) ? adr(j_reg, k_reg) : adr(i_reg, k_reg);
    assign b_addr   = (phase_reg == PH_U) ? adr(k_reg, j_reg) : adr(k_reg, i_reg);

    always_ff @(posedge clk)
    begin
        if (lu_we)
            lu_mem[lu_addr] <= lu_wd;
        rd_lu <= lu_mem[lu_addr];
        if (vec_we)
            vec_mem[vec_addr] <= vec_wd;
        rd_vec <= vec_mem[vec_addr];
        prod_reg <= 64'(ma_reg) * 64'(mb_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            phase_reg <= PH_U;
            size_reg  <= 4'd8;
            sing_reg  <= 1'b0;
            n_reg     <= 4'd1;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            if (cfg_we)
                size_reg <= cfg_data;
            sing_reg <= sing_next;
            if (in_acc && last)
                n_reg <= n_eff;
            i_reg <= i_next;
            j_reg <= j_next;
            k_reg <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        a_reg     <= a_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        pivot_reg <= pivot_next;
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        sing_next = sing_reg;
        acc_next = acc_reg;
        a_next = a_reg;
        ma_next = ma_reg;
        mb_next = mb_reg;
        pivot_next = pivot_reg;
        lu_addr = tgt_addr;
        lu_we = 1'b0;
        lu_wd = value;
        vec_addr = IW'(i_reg);
        vec_we = 1'b0;
        vec_wd = value;
        div_start = 1'b0;
        out_valid = 1'b0;
        index = i_reg[2:0];
        solution = sing_reg ? 32'sd0 : rd_vec;
        singular = sing_reg;
        end_of_run = (i_reg + 4'd1 == n_reg);
        case (state_reg)
            ST_LOAD:
            begin
                lu_addr  = adr({1'b0, row}, {1'b0, col});
                vec_addr = IW'(row);
                if (in_acc)
                begin
                    lu_we  = in_ok && !mode;
                    vec_we = in_ok && mode;
                    if (last)
                    begin
                        sing_next  = 1'b0;
                        phase_next = PH_U;
                        i_next     = '0;
                        j_next     = '0;
                        state_next = ST_ELEM;
                    end
                end
            end
            ST_ELEM:
            begin
                k_next     = k_start;
                state_next = ST_TGT;
            end
            ST_TGT:
            begin
                a_next   = is_vec ? rd_vec : rd_lu;
                acc_next = '0;
                if (k_reg < k_end)
                begin
                    lu_addr    = a_addr;
                    vec_addr   = IW'(k_reg);
                    state_next = ST_TERM_B;
                end
                else
                    state_next = ST_FIN;
            end
            ST_TERM_B:
            begin
                ma_next    = rd_lu;
                lu_addr    = b_addr;
                vec_addr   = IW'(k_reg);
                state_next = ST_TERM_M;
            end
            ST_TERM_M:
            begin
                mb_next    = is_vec ? rd_vec : rd_lu;
                k_next     = k_reg + 4'd1;
                state_next = ST_TERM_P;
            end
            ST_TERM_P:
            begin
                state_next = ST_TERM_ACC;
            end
            ST_TERM_ACC:
            begin
                acc_next = acc_reg + 66'(prod_reg >>> FRAC_BITS);
                if (k_reg < k_end)
                begin
                    lu_addr    = a_addr;
                    vec_addr   = IW'(k_reg);
                    state_next = ST_TERM_B;
                end
                else
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                case (phase_reg)
                    PH_U:
                    begin
                        lu_we = 1'b1;
                        lu_wd = diff;
                        if (j_reg == i_reg)
                            pivot_next = diff;
                        if (j_reg + 4'd1 < n_reg)
                        begin
                            j_next     = j_reg + 4'd1;
                            state_next = ST_ELEM;
                        end
                        else
                            state_next = ST_CHECK;
                    end
                    PH_L:
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV_WAIT;
                    end
                    PH_F:
                    begin
                        vec_we = 1'b1;
                        vec_wd = diff;
                        if (i_reg + 4'd1 < n_reg)
                            i_next = i_reg + 4'd1;
                        else
                        begin
                            phase_next = PH_B;
                            i_next     = n_reg - 4'd1;
                        end
                        state_next = ST_ELEM;
                    end
                    PH_B:
                    begin
                        lu_addr    = adr(i_reg, i_reg);
                        state_next = ST_PIV;
                    end
                    default:
                    begin
                        state_next = ST_LOAD;
                    end
                endcase
            end
            ST_CHECK:
            begin
                if (pivot_reg == 32'sd0)
                begin
                    sing_next  = 1'b1;
                    i_next     = '0;
                    state_next = ST_OUT_RD;
                end
                else if (i_reg + 4'd1 >= n_reg)
                begin
                    phase_next = PH_F;
                    i_next     = '0;
                    state_next = ST_ELEM;
                end
                else
                begin
                    phase_next = PH_L;
                    j_next     = i_reg + 4'd1;
                    state_next = ST_ELEM;
                end
            end
            ST_PIV:
            begin
                pivot_next = rd_lu;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_ctl.done)
                begin
                    if (phase_reg == PH_L)
                    begin
                        lu_we = 1'b1;
                        lu_wd = div_quo;
                        if (j_reg + 4'd1 < n_reg)
                            j_next = j_reg + 4'd1;
                        else
                        begin
                            phase_next = PH_U;
                            i_next     = i_reg + 4'd1;
                            j_next     = i_reg + 4'd1;
                        end
                        state_next = ST_ELEM;
                    end
                    else
                    begin
                        vec_we = 1'b1;
                        vec_wd = div_quo;
                        if (i_reg == 4'd0)
                            state_next = ST_OUT_RD;
                        else
                        begin
                            i_next     = i_reg - 4'd1;
                            state_next = ST_ELEM;
                        end
                    end
                end
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    if (i_reg + 4'd1 >= n_reg)
                        state_next = ST_LOAD;
                    else
                    begin
                        i_next     = i_reg + 4'd1;
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end
endmodule

// ----- verif/lu_linear_system_solver_tb.sv -----
// Self-checking testbench for lu_linear_system_solver: loads random and directed
// linear systems, predicts the LU solve in fixed point and checks each solution item.
// Depends on lu_pkg and the solver RTL.
`timescale 1ns / 1ps

module lu_linear_system_solver_tb;
    import lu_pkg::*;

    localparam bit MODE_MATRIX = 1'b0;
    localparam bit MODE_VECTOR = 1'b1;
    localparam int FRAC = 16;
    localparam int SIZE_MAX = 8;

    typedef struct {
        logic [2:0] index;
        fx_t        solution;
        logic       singular;
        logic       end_of_run;
    } solution_item_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [3:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        mode;
    logic [2:0]  row;
    logic [2:0]  col;
    fx_t         value;
    logic        last;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  index;
    fx_t         solution;
    logic        singular;
    logic        end_of_run;

    fx_t            coeff_mem [SIZE_MAX*SIZE_MAX];
    fx_t            rhs_mem [SIZE_MAX];
    logic [3:0]     size_reg;
    solution_item_t pending_solutions [$];
    int             failures;
    bit             hold_off;

    lu_linear_system_solver dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .row(row), .col(col),
        .value(value), .last(last), .out_valid(out_valid), .out_stall(out_stall),
        .index(index), .solution(solution), .singular(singular), .end_of_run(end_of_run)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic fx_t sat_fx(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [65:0] mul_floor(input fx_t a, input fx_t b);
        logic signed [65:0] p;
        p = 66'(a) * 66'(b);
        return p >>> FRAC;
    endfunction

    function automatic fx_t div_trunc(input fx_t num, input fx_t den);
        logic signed [65:0] scaled;
        scaled = 66'(num) * 66'sd65536;
        return sat_fx(scaled / 66'(den));
    endfunction

    task automatic solve_system();
        int n;
        bit sing;
        logic signed [65:0] acc;
        solution_item_t it;
        n = size_reg;
        if (n == 0)
            n = 1;
        if (n > SIZE_MAX)
            n = SIZE_MAX;
        sing = 1'b0;
        for (int i = 0; i < n && !sing; i++)
        begin
            for (int j = i; j < n; j++)
            begin
                acc = 0;
                for (int k = 0; k < i; k++)
                    acc += mul_floor(coeff_mem[i*8+k], coeff_mem[k*8+j]);
                coeff_mem[i*8+j] = sat_fx(66'(coeff_mem[i*8+j]) - acc);
            end
            if (coeff_mem[i*8+i] == 0)
            begin
                sing = 1'b1;
                break;
            end
            for (int j = i + 1; j < n; j++)
            begin
                acc = 0;
                for (int k = 0; k < i; k++)
                    acc += mul_floor(coeff_mem[j*8+k], coeff_mem[k*8+i]);
                coeff_mem[j*8+i] = div_trunc(sat_fx(66'(coeff_mem[j*8+i]) - acc),
                                             coeff_mem[i*8+i]);
            end
        end
        if (!sing)
        begin
            for (int i = 0; i < n; i++)
            begin
                acc = 0;
                for (int j = 0; j < i; j++)
                    acc += mul_floor(coeff_mem[i*8+j], rhs_mem[j]);
                rhs_mem[i] = sat_fx(66'(rhs_mem[i]) - acc);
            end
            for (int i = n - 1; i >= 0; i--)
            begin
                acc = 0;
                for (int j = i + 1; j < n; j++)
                    acc += mul_floor(coeff_mem[i*8+j], rhs_mem[j]);
                rhs_mem[i] = div_trunc(sat_fx(66'(rhs_mem[i]) - acc), coeff_mem[i*8+i]);
            end
        end
        for (int i = 0; i < n; i++)
        begin
            it.index = i[2:0];
            it.solution = sing ? 32'sd0 : rhs_mem[i];
            it.singular = sing;
            it.end_of_run = (i == n - 1);
            pending_solutions.insert(pending_solutions.size(), it);
        end
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_entry(input bit m, input logic [2:0] r, input logic [2:0] c,
                              input fx_t v, input bit l, input bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g != 0)
        begin
            in_valid <= 1'b0;
            repeat (g)
                @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        row <= r;
        col <= c;
        value <= v;
        last <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (m == MODE_MATRIX)
            coeff_mem[r*8+c] = v;
        else
            rhs_mem[r] = v;
        if (l)
            solve_system();
        @(negedge clk);
    endtask

    task automatic wait_idle();
        int t;
        t = 0;
        in_valid <= 1'b0;
        while (pending_solutions.size() != 0 && t < 400000)
        begin
            @(negedge clk);
            t++;
        end
        repeat (200)
            @(negedge clk);
    endtask

    task automatic set_size(input int n);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_data <= n[3:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        size_reg = n[3:0];
    endtask

    function automatic fx_t rand_fx();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'sh7fffffff;
            2: return 32'sh80000000;
            default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        endcase
    endfunction

    // Loads a full system; diagonal boosted unless a raw matrix is asked for.
    task automatic load_system(input int n, input bit raw, input bit gaps);
        fx_t v;
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
            begin
                v = raw ? rand_fx() : $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
                if (!raw && r == c)
                    v = v + 32'sh0008_0000;
                send_entry(MODE_MATRIX, r[2:0], c[2:0], v, 1'b0, gaps);
            end
        for (int r = 0; r < n - 1; r++)
            send_entry(MODE_VECTOR, r[2:0], 3'($urandom), rand_fx(), 1'b0, gaps);
        send_entry(MODE_VECTOR, 3'(n - 1), 3'($urandom), rand_fx(), 1'b1, gaps);
    endtask

    task automatic test_directed();
        set_size(1);
        send_entry(MODE_MATRIX, 3'd0, 3'd0, 32'sh0001_0000, 1'b0, 1'b0);
        send_entry(MODE_VECTOR, 3'd0, 3'd7, 32'sh7fffffff, 1'b1, 1'b0);
        send_entry(MODE_MATRIX, 3'd0, 3'd0, 32'sh0000_0001, 1'b0, 1'b0);
        send_entry(MODE_VECTOR, 3'd0, 3'd0, 32'sh80000000, 1'b1, 1'b0);
        send_entry(MODE_MATRIX, 3'd0, 3'd0, 32'sh0, 1'b0, 1'b0);
        send_entry(MODE_VECTOR, 3'd0, 3'd0, 32'sh0001_0000, 1'b1, 1'b0);
        set_size(0);
        send_entry(MODE_MATRIX, 3'd0, 3'd0, 32'shffff_0000, 1'b0, 1'b0);
        send_entry(MODE_VECTOR, 3'd0, 3'd0, 32'sh0003_0000, 1'b1, 1'b0);
        set_size(2);
        send_entry(MODE_MATRIX, 3'd0, 3'd0, 32'sh0, 1'b0, 1'b0);
        send_entry(MODE_MATRIX, 3'd0, 3'd1, 32'sh0001_0000, 1'b0, 1'b0);
        send_entry(MODE_MATRIX, 3'd1, 3'd0, 32'sh0001_0000, 1'b0, 1'b0);
        send_entry(MODE_MATRIX, 3'd1, 3'd1, 32'sh0001_0000, 1'b0, 1'b0);
        send_entry(MODE_VECTOR, 3'd0, 3'd0, 32'sh0001_0000, 1'b0, 1'b0);
        send_entry(MODE_VECTOR, 3'd1, 3'd0, 32'sh0002_0000, 1'b1, 1'b0);
        set_size(15);
        load_system(8, 1'b0, 1'b0);
    endtask

    task automatic test_random();
        int n;
        for (int s = 0; s < 4; s++)
        begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
            set_size(n);
            load_system(n, $urandom_range(0, 3) == 0, 1'b1);
        end
    endtask

    task automatic test_backpressure();
        set_size(3);
        hold_off = 1'b1;
        load_system(3, 1'b0, 1'b0);
        load_system(3, 1'b1, 1'b0);
        set_size(4);
        load_system(4, 1'b1, 1'b1);
    endtask

    always @(posedge clk)
    begin
        solution_item_t exp_item;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_solutions.size() == 0)
            begin
                $error("unexpected result index=%0d", index);
                failures++;
            end
            else
            begin
                exp_item = pending_solutions.pop_front();
                if (index !== exp_item.index)
                begin
                    $error("index expected %0d actual %0d", exp_item.index, index);
                    failures++;
                end
                if (solution !== exp_item.solution)
                begin
                    $error("solution expected %h actual %h", exp_item.solution, solution);
                    failures++;
                end
                if (singular !== exp_item.singular)
                begin
                    $error("singular expected %0b actual %0b", exp_item.singular, singular);
                    failures++;
                end
                if (end_of_run !== exp_item.end_of_run)
                begin
                    $error("end_of_run expected %0b actual %0b", exp_item.end_of_run,
                           end_of_run);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        int g;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (3000)
                    @(negedge clk);
                out_stall <= 1'b0;
                hold_off = 1'b0;
            end
            else
            begin
                g = gap_len();
                if (g != 0)
                begin
                    out_stall <= 1'b1;
                    repeat (g)
                        @(negedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        #4000000;
        $display("lu_linear_system_solver_tb NOT OK");
        $finish;
    end

    initial
    begin
        failures = 0;
        hold_off = 1'b0;
        size_reg = 4'd8;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 4'd0;
        in_valid = 1'b0;
        mode = 1'b0;
        row = 3'd0;
        col = 3'd0;
        value = 32'sd0;
        last = 1'b0;
        repeat (9)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_backpressure();
        test_random();
        wait_idle();
        if (failures == 0 && pending_solutions.size() == 0)
            $display("lu_linear_system_solver_tb OK");
        else
            $display("lu_linear_system_solver_tb NOT OK");
        $finish;
    end
endmodule
